[hdl/slt_pkg.sv]
// Shared types and fixed constants for the sine LFO tremolo unit.
// Used by sine_lfo_tremolo_unit and slt_checker; no dependencies.
package slt_pkg;

    // Configuration port
    localparam int          ADDR_W    = 3;
    localparam logic        REG_RATE  = 1'b0;
    localparam logic        REG_DEPTH = 1'b1;
    localparam logic [9:0]  RATE_RESET  = 10'd512;
    localparam logic [9:0]  DEPTH_RESET = 10'd512;

    // Rate knob width, one increment update step per bit
    localparam int          RATE_BITS = 10;

    // Sine table quantization
    localparam int          SINE_TABLE_DEPTH = 1024;
    localparam int          SINE_TABLE_LOG2  = $clog2(SINE_TABLE_DEPTH);
    localparam logic [31:0] U_MASK = ~((32'd1 << (32 - SINE_TABLE_LOG2)) - 32'd1);

    // Q30 quarter-sine polynomial
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598668;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172272;

    // Divide by 1023 through a reciprocal with one correction
    localparam logic [25:0] DIV_CONST   = 26'd1023;
    localparam int          RECIP_SHIFT = 36;
    localparam longint      RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 1023;
    localparam logic [31:0] RECIP       = RECIP_FULL[31:0];
    localparam logic [16:0] GAIN_ONE    = 17'd65536;
    localparam logic [25:0] DL_BIAS     = 26'd511;

    // Sequencer states
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_X2    = 13'b0000000000010,
        ST_H9    = 13'b0000000000100,
        ST_H7    = 13'b0000000001000,
        ST_H5    = 13'b0000000010000,
        ST_H3    = 13'b0000000100000,
        ST_H1    = 13'b0000001000000,
        ST_LFO   = 13'b0000010000000,
        ST_DL    = 13'b0000100000000,
        ST_DIV   = 13'b0001000000000,
        ST_GAIN  = 13'b0010000000000,
        ST_LEFT  = 13'b0100000000000,
        ST_RIGHT = 13'b1000000000000
    } t_state;

endpackage

[hdl/sine_lfo_tremolo_unit.sv]
// An input beat steps through X2, H9, H7, H5, H3, H1, LFO, DL, DIV, GAIN, LEFT, RIGHT;
// its result beat goes valid after RIGHT, which waits while the output is stalled. One
// stereo frame is worked on at a time, set by the single shared 32x32 multiplier that
// steps through the sine polynomial, gain and both channels. A rate write recomputes the
// phase increment, one add and compare step per rate bit then a load; no input beat is taken meanwhile.
// Reset (synchronous, active low) clears phase, loads knobs to 512, runs the update.
module sine_lfo_tremolo_unit #(
    parameter int PHASE_BITS     = 32,
    parameter int SAMPLE_RATE_HZ = 48000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [slt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [23:0]         i_left_sample,
    input  logic signed [23:0]         i_right_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [23:0]         o_left_out,
    output logic signed [23:0]         o_right_out
);

    localparam int unsigned DEN   = 10230 * SAMPLE_RATE_HZ;
    localparam int          DEN_W = $clog2(DEN + 1);
    localparam int          D2_W  = DEN_W + 1;
    localparam int          SUM_W = D2_W + 1;
    localparam int          CNT_W = $clog2(slt_pkg::RATE_BITS + 1);
    localparam int          EXT_W = PHASE_BITS + 32;
    localparam int          SH_L  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int          SH_R  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;

    // Increment = floor((num * 2^(PHASE_BITS+1) + DEN) / (2 * DEN)), num = 1023 + 99 * rate.
    // Base term (1023) and step term (99) are each kept as quotient and remainder.
    localparam longint unsigned D2     = 64'd2 * 64'(DEN);
    localparam longint unsigned M_BASE = (64'd1023 << (PHASE_BITS + 1)) + 64'(DEN);
    localparam longint unsigned M_STEP = 64'd99 << (PHASE_BITS + 1);
    localparam longint unsigned Q_BASE = M_BASE / D2;
    localparam longint unsigned R_BASE = M_BASE % D2;
    localparam longint unsigned Q_STEP = M_STEP / D2;
    localparam longint unsigned R_STEP = M_STEP % D2;

    slt_pkg::t_state r_state, n_state;

    logic [9:0]                    r_rate, r_depth;
    logic [PHASE_BITS-1:0]         r_phase, r_inc, r_quo, r_dq;
    logic                          r_div_busy;
    logic [CNT_W-1:0]              r_div_cnt;
    logic [D2_W-1:0]               r_rem, r_dr;
    logic [slt_pkg::RATE_BITS-1:0] r_rsh;

    logic signed [23:0] r_left, r_right, r_lres, r_left_out, r_right_out;
    logic               r_out_valid;
    logic [30:0]        r_x, r_x2, r_t;
    logic [1:0]         r_quad;
    logic [15:0]        r_lfo, r_q;
    logic [25:0]        r_v;
    logic [16:0]        r_gain;

    logic w_cfg_wr, w_rate_wr, w_depth_wr, w_accept, w_out_free;

    // APB decode
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_rate_wr  = w_cfg_wr && (paddr[2] == slt_pkg::REG_RATE);
    assign w_depth_wr = w_cfg_wr && (paddr[2] == slt_pkg::REG_DEPTH);
    assign prdata     = (paddr[2] == slt_pkg::REG_DEPTH) ? {22'd0, r_depth} : {22'd0, r_rate};

    assign o_in_ready  = (r_state == slt_pkg::ST_IDLE) && !r_div_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // Increment update: add the step term for each set rate bit, doubling it at each step
    logic [SUM_W-1:0] w_d2, w_acc_sum, w_dbl;
    logic             w_acc_ge, w_dbl_ge;

    assign w_d2      = SUM_W'(D2);
    assign w_acc_sum = {1'b0, r_rem} + {1'b0, r_dr};
    assign w_acc_ge  = (w_acc_sum >= w_d2);
    assign w_dbl     = {r_dr, 1'b0};
    assign w_dbl_ge  = (w_dbl >= w_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= CNT_W'(slt_pkg::RATE_BITS);
            r_rsh      <= slt_pkg::RATE_RESET;
            r_quo      <= PHASE_BITS'(Q_BASE);
            r_rem      <= D2_W'(R_BASE);
            r_dq       <= PHASE_BITS'(Q_STEP);
            r_dr       <= D2_W'(R_STEP);
        end else if (w_rate_wr) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= CNT_W'(slt_pkg::RATE_BITS);
            r_rsh      <= pwdata[9:0];
            r_quo      <= PHASE_BITS'(Q_BASE);
            r_rem      <= D2_W'(R_BASE);
            r_dq       <= PHASE_BITS'(Q_STEP);
            r_dr       <= D2_W'(R_STEP);
        end else if (r_div_busy) begin
            if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - CNT_W'(1);
                r_rsh     <= r_rsh >> 1;
                if (r_rsh[0]) begin
                    r_quo <= r_quo + r_dq + PHASE_BITS'(w_acc_ge);
                    r_rem <= w_acc_ge ? D2_W'(w_acc_sum - w_d2) : w_acc_sum[D2_W-1:0];
                end
                r_dq <= {r_dq[PHASE_BITS-2:0], w_dbl_ge};
                r_dr <= w_dbl_ge ? D2_W'(w_dbl - w_d2) : w_dbl[D2_W-1:0];
            end else begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // Load the rounded increment once every rate bit is in
    always_ff @(posedge i_clk) begin
        if (r_div_busy && (r_div_cnt == '0) && !w_rate_wr) begin
            r_inc <= r_quo;
        end
    end

    // Table angle from the top 32 phase bits, folded into the first quadrant
    logic [EXT_W-1:0] w_ext;
    logic [31:0]      w_u;
    logic [1:0]       w_quad;
    logic [30:0]      w_x;

    assign w_ext  = (EXT_W'(r_phase) << SH_L) >> SH_R;
    assign w_u    = w_ext[31:0] & slt_pkg::U_MASK;
    assign w_quad = w_u[31:30];
    assign w_x    = w_quad[0] ? slt_pkg::Q30_ONE - {1'b0, w_u[29:0]} : {1'b0, w_u[29:0]};

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::ST_IDLE:  if (w_accept) n_state = slt_pkg::ST_X2;
            slt_pkg::ST_X2:    n_state = slt_pkg::ST_H9;
            slt_pkg::ST_H9:    n_state = slt_pkg::ST_H7;
            slt_pkg::ST_H7:    n_state = slt_pkg::ST_H5;
            slt_pkg::ST_H5:    n_state = slt_pkg::ST_H3;
            slt_pkg::ST_H3:    n_state = slt_pkg::ST_H1;
            slt_pkg::ST_H1:    n_state = slt_pkg::ST_LFO;
            slt_pkg::ST_LFO:   n_state = slt_pkg::ST_DL;
            slt_pkg::ST_DL:    n_state = slt_pkg::ST_DIV;
            slt_pkg::ST_DIV:   n_state = slt_pkg::ST_GAIN;
            slt_pkg::ST_GAIN:  n_state = slt_pkg::ST_LEFT;
            slt_pkg::ST_LEFT:  n_state = slt_pkg::ST_RIGHT;
            slt_pkg::ST_RIGHT: if (w_out_free) n_state = slt_pkg::ST_IDLE;
            default:           n_state = slt_pkg::ST_IDLE;
        endcase
    end

    // Control registers, knobs and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slt_pkg::ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= slt_pkg::RATE_RESET;
            r_depth     <= slt_pkg::DEPTH_RESET;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= r_phase + r_inc;
            end
            if ((r_state == slt_pkg::ST_RIGHT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_rate_wr) begin
                r_rate <= pwdata[9:0];
            end
            if (w_depth_wr) begin
                r_depth <= pwdata[9:0];
            end
        end
    end

    // Shared multiplier operand select
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod, w_round;
    logic [32:0]        w_shift30;
    logic [30:0]        w_hconst;

    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_hconst = slt_pkg::C1;
        case (r_state)
            slt_pkg::ST_X2: begin
                w_ma = {1'b0, r_x};
                w_mb = {1'b0, r_x};
            end
            slt_pkg::ST_H9: begin
                w_ma     = {1'b0, r_x2};
                w_mb     = {1'b0, slt_pkg::C9};
                w_hconst = slt_pkg::C7;
            end
            slt_pkg::ST_H7: begin
                w_ma     = {1'b0, r_x2};
                w_mb     = {1'b0, r_t};
                w_hconst = slt_pkg::C5;
            end
            slt_pkg::ST_H5: begin
                w_ma     = {1'b0, r_x2};
                w_mb     = {1'b0, r_t};
                w_hconst = slt_pkg::C3;
            end
            slt_pkg::ST_H3: begin
                w_ma     = {1'b0, r_x2};
                w_mb     = {1'b0, r_t};
                w_hconst = slt_pkg::C1;
            end
            slt_pkg::ST_H1: begin
                w_ma = {1'b0, r_x};
                w_mb = {1'b0, r_t};
            end
            slt_pkg::ST_DL: begin
                w_ma = {22'd0, r_depth};
                w_mb = {16'd0, r_lfo};
            end
            slt_pkg::ST_DIV: begin
                w_ma = {6'd0, r_v};
                w_mb = slt_pkg::RECIP;
            end
            slt_pkg::ST_LEFT: begin
                w_ma = {{8{r_left[23]}}, r_left};
                w_mb = {15'd0, r_gain};
            end
            slt_pkg::ST_RIGHT: begin
                w_ma = {{8{r_right[23]}}, r_right};
                w_mb = {15'd0, r_gain};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod    = w_ma * w_mb;
    assign w_shift30 = w_prod[62:30];
    assign w_round   = w_prod + 64'sd32768;

    // lfo = ((2^30 + s) * 65535 + 2^30) >> 31, as shift and subtract
    logic [31:0] w_v;
    logic [48:0] w_lfo_sum;

    assign w_v       = r_quad[1] ? 32'(slt_pkg::Q30_ONE) - 32'(r_t)
                                 : 32'(slt_pkg::Q30_ONE) + 32'(r_t);
    assign w_lfo_sum = (49'(w_v) << 16) - 49'(w_v) + 49'(slt_pkg::Q30_ONE);

    // Correct the reciprocal quotient by one and form the gain
    logic [25:0] w_q1023, w_qrem;
    logic [16:0] w_dl;

    assign w_q1023 = {r_q, 10'd0} - 26'(r_q);
    assign w_qrem  = r_v - w_q1023;
    assign w_dl    = 17'(r_q) + 17'(w_qrem >= slt_pkg::DIV_CONST);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            slt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_left  <= i_left_sample;
                    r_right <= i_right_sample;
                    r_x     <= w_x;
                    r_quad  <= w_quad;
                end
            end
            slt_pkg::ST_X2: r_x2 <= w_shift30[30:0];
            slt_pkg::ST_H9, slt_pkg::ST_H7, slt_pkg::ST_H5, slt_pkg::ST_H3: begin
                r_t <= 31'(33'(w_hconst) - w_shift30);
            end
            slt_pkg::ST_H1: begin
                r_t <= (w_shift30 > 33'(slt_pkg::Q30_ONE)) ? slt_pkg::Q30_ONE
                                                          : w_shift30[30:0];
            end
            slt_pkg::ST_LFO:  r_lfo  <= w_lfo_sum[46:31];
            slt_pkg::ST_DL:   r_v    <= w_prod[25:0] + slt_pkg::DL_BIAS;
            slt_pkg::ST_DIV:  r_q    <= w_prod[slt_pkg::RECIP_SHIFT +: 16];
            slt_pkg::ST_GAIN: r_gain <= slt_pkg::GAIN_ONE - w_dl;
            slt_pkg::ST_LEFT: r_lres <= w_round[39:16];
            slt_pkg::ST_RIGHT: begin
                if (w_out_free) begin
                    r_left_out  <= r_lres;
                    r_right_out <= w_round[39:16];
                end
            end
            default: begin
                r_lres <= r_lres;
            end
        endcase
    end

endmodule

[hdl/slt_checker.sv]
// Port-level checks for sine_lfo_tremolo_unit, bound to the top level.
// Depends on slt_pkg for the register index codes.
module slt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [slt_pkg::ADDR_W-1:0] paddr,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [23:0]         o_left_out,
    input logic signed [23:0]         o_right_out
);

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // Hold result payload while stalled
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_left_out) && $stable(o_right_out))
        else $error("result payload changed while stalled");

    // Drop ready after each input beat while the frame is worked on
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a frame is in progress");

    // Drop ready while the increment is recomputed after a rate write
    a_busy_after_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == slt_pkg::REG_RATE) |=> !o_in_ready)
        else $error("input ready during increment recompute");

endmodule

bind sine_lfo_tremolo_unit slt_checker u_slt_checker (.*);

[dv/sine_lfo_tremolo_unit_tb.sv]
// Self-checking bench for sine_lfo_tremolo_unit: a directed stimulus table, then random
// stereo beats under three idle regimes, each result checked against a tremolo predictor.
// Depends on slt_pkg (port widths, register select codes) and the unit RTL.
module sine_lfo_tremolo_unit_tb;

    localparam int     CLK_HALF       = 4;
    localparam int     PHASE_BITS     = 32;
    localparam int     SAMPLE_RATE_HZ = 48000;
    localparam longint unsigned TABLE_DEPTH = 1024;

    // Q30 quarter-sine polynomial
    localparam longint Q30_UNIT = 64'sd1073741824;
    localparam longint POLY_K1  = 1686629713;
    localparam longint POLY_K3  = 693598668;
    localparam longint POLY_K5  = 85569306;
    localparam longint POLY_K7  = 5026995;
    localparam longint POLY_K9  = 172272;

    localparam int RAND_PER_PHASE = 466;
    localparam int RETUNE_EVERY   = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 32;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        ROW_FRAME,
        ROW_RATE,
        ROW_DEPTH
    } row_op_e;

    typedef struct packed {
        row_op_e op;
        int      a;
        int      b;
        logic    typed;
        int      ea;
        int      eb;
    } stim_row_t;

    typedef struct packed {
        logic signed [23:0] left_s;
        logic signed [23:0] right_s;
    } frame_t;

    typedef struct packed {
        logic   typed;
        frame_t frame;
    } frame_note_t;

    // Directed rows: typed results only where obvious (after reset, zero depth, silence)
    localparam int DIR_ROWS = 22;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_FRAME, -8388608,     0,        1'b1, -6289408, 0},
        '{ROW_FRAME, 0,            0,        1'b1, 0,        0},
        '{ROW_FRAME, 8388607,      -8388608, 1'b0, 0,        0},
        '{ROW_FRAME, -1,           1,        1'b0, 0,        0},
        '{ROW_FRAME, 1,            -1,       1'b0, 0,        0},
        '{ROW_FRAME, 8388607,      8388607,  1'b0, 0,        0},
        '{ROW_DEPTH, 32'hFFFF_FC00, 0,       1'b0, 0,        0},
        '{ROW_FRAME, 8388607,      -8388608, 1'b1, 8388607,  -8388608},
        '{ROW_FRAME, -1,           1,        1'b1, -1,       1},
        '{ROW_FRAME, 5592405,      -5592406, 1'b1, 5592405,  -5592406},
        '{ROW_RATE,  32'hFFFF_FFFF, 0,       1'b0, 0,        0},
        '{ROW_FRAME, -8388608,     8388607,  1'b1, -8388608, 8388607},
        '{ROW_DEPTH, 1023,         0,        1'b0, 0,        0},
        '{ROW_FRAME, 8388607,      -8388608, 1'b0, 0,        0},
        '{ROW_FRAME, -8388608,     8388607,  1'b0, 0,        0},
        '{ROW_FRAME, 0,            0,        1'b1, 0,        0},
        '{ROW_RATE,  32'h0000_0400, 0,       1'b0, 0,        0},
        '{ROW_FRAME, 123456,       -654321,  1'b0, 0,        0},
        '{ROW_DEPTH, 32'h8000_0001, 0,       1'b0, 0,        0},
        '{ROW_FRAME, 8388607,      -8388608, 1'b0, 0,        0},
        '{ROW_RATE,  512,          0,        1'b0, 0,        0},
        '{ROW_FRAME, -4194304,     4194303,  1'b0, 0,        0}
    };

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [slt_pkg::ADDR_W-1:0] paddr          = '0;
    logic [31:0]                pwdata         = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_ready;
    logic signed [23:0]         i_left_sample  = '0;
    logic signed [23:0]         i_right_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready    = 1'b0;
    logic signed [23:0]         o_left_out;
    logic signed [23:0]         o_right_out;

    // Predictor state and knob shadows
    logic [31:0] lfo_phase_q = '0;
    logic [9:0]  rate_q      = 10'd512;
    logic [9:0]  depth_q     = 10'd512;

    frame_t      gained_q [$];
    frame_note_t note_q [$];

    int   fail_cnt     = 0;
    int   tx_idle_pct  = 35;
    int   rx_idle_pct  = 45;
    logic rx_hold_req  = 1'b0;
    logic rx_hold_seen = 1'b0;
    int   rx_hold_left = 0;

    sine_lfo_tremolo_unit #(
        .PHASE_BITS     (PHASE_BITS),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Round half up of (1023 + 99*rate) * 2^32 / (10230 * fs)
    function automatic logic [31:0] phase_increment_for(input logic [9:0] rate);
        longint unsigned num;
        longint unsigned den;
        num = 64'd1023 + 64'd99 * rate;
        den = 64'd10230 * SAMPLE_RATE_HZ;
        return 32'(((num << (PHASE_BITS + 1)) + den) / (64'd2 * den));
    endfunction

    function automatic longint quarter_sine_q30(input longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 30;
        t = POLY_K7 - ((x2 * POLY_K9) >>> 30);
        t = POLY_K5 - ((x2 * t) >>> 30);
        t = POLY_K3 - ((x2 * t) >>> 30);
        t = POLY_K1 - ((x2 * t) >>> 30);
        t = (x * t) >>> 30;
        return (t > Q30_UNIT) ? Q30_UNIT : t;
    endfunction

    // Table lookup: index from the top phase bits, quadrant folding, then (1+sin)/2 in Q0.16
    function automatic longint lfo_from_phase(input logic [31:0] phase);
        longint unsigned top;
        longint unsigned idx;
        longint unsigned u;
        longint          x;
        longint          s;
        top = phase;
        idx = (top * TABLE_DEPTH) >> 32;
        u = (idx << 32) / TABLE_DEPTH;
        x = longint'(u[29:0]);
        if (u[30]) begin
            x = Q30_UNIT - x;
        end
        s = quarter_sine_q30(x);
        if (u[31]) begin
            s = -s;
        end
        return ((Q30_UNIT + s) * 65535 + Q30_UNIT) >>> 31;
    endfunction

    function automatic longint gain_for(input logic [9:0] depth, input longint lfo);
        return 65536 - (longint'(depth) * lfo + 511) / 1023;
    endfunction

    function automatic logic signed [23:0] apply_gain(input logic signed [23:0] smp,
                                                      input longint gain);
        longint p;
        p = longint'(smp) * gain;
        return 24'((p + 32768) >>> 16);
    endfunction

    function automatic void note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void check_value(input string what, input logic signed [31:0] got,
                                        input logic signed [31:0] want);
        if (got !== want) begin
            note_failure($sformatf("mismatch on %s: expected %0d, got %0d", what, want, got));
        end
    endfunction

    function automatic logic signed [23:0] pick_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return 24'($urandom);
        end
        if (pick < 85) begin
            case ($urandom_range(4))
                0: return 24'h7F_FFFF;
                1: return 24'h80_0000;
                2: return 24'h00_0000;
                3: return 24'hFF_FFFF;
                default: return 24'h00_0001;
            endcase
        end
        return 24'(int'($urandom_range(511)) - 256);
    endfunction

    // Hold valid low for a random number of cycles
    task automatic idle_sender();
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Offer one beat and hold it until accepted
    task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                              input logic typed, input logic signed [23:0] el,
                              input logic signed [23:0] er);
        frame_note_t note;
        note.typed         = typed;
        note.frame.left_s  = el;
        note.frame.right_s = er;
        note_q.push_back(note);
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every expected beat has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (gained_q.size() != 0);
    endtask

    // Write a knob, update its shadow, read it back
    task automatic program_knob(input logic reg_sel, input logic [31:0] value);
        logic [slt_pkg::ADDR_W-1:0] addr;
        logic [31:0]                readback;
        addr = {reg_sel, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == slt_pkg::REG_RATE) begin
            rate_q = value[9:0];
        end else begin
            depth_q = value[9:0];
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_value(reg_sel == slt_pkg::REG_RATE ? "rate readback" : "depth readback",
                    readback, {22'd0, value[9:0]});
    endtask

    // Predict each accepted input beat and advance the phase
    always @(posedge i_clk) begin : track_in
        frame_note_t note;
        frame_t      want;
        longint      gain;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            gain = gain_for(depth_q, lfo_from_phase(lfo_phase_q));
            want.left_s  = apply_gain(i_left_sample, gain);
            want.right_s = apply_gain(i_right_sample, gain);
            if (note_q.size() != 0) begin
                note = note_q.pop_front();
                if (note.typed) begin
                    want = note.frame;
                end
            end
            gained_q.push_back(want);
            lfo_phase_q = lfo_phase_q + phase_increment_for(rate_q);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_out
        frame_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gained_q.size() == 0) begin
                note_failure($sformatf("result beat with nothing expected: left %0d right %0d",
                                       o_left_out, o_right_out));
            end else begin
                want = gained_q.pop_front();
                check_value("left_out", o_left_out, want.left_s);
                check_value("right_out", o_right_out, want.right_s);
            end
        end
    end

    // Drive ready: long hold on request, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : main_seq
        stim_row_t   row;
        logic [31:0] noise;
        int unsigned pick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TABLE[i];
            case (row.op)
                ROW_FRAME: begin
                    idle_sender();
                    send_frame(row.a[23:0], row.b[23:0], row.typed, row.ea[23:0], row.eb[23:0]);
                end
                ROW_RATE: begin
                    drain_results();
                    program_knob(slt_pkg::REG_RATE, row.a);
                end
                default: begin
                    drain_results();
                    program_knob(slt_pkg::REG_DEPTH, row.a);
                end
            endcase
        end

        // Random beats: receiver-heavy idling, sender-heavy idling, then none
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct <= 45;
                end
                1: begin
                    tx_idle_pct = 45;
                    rx_idle_pct <= 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // Retune both knobs while idle, depth first, rate biased high
                if (n % RETUNE_EVERY == 0) begin
                    drain_results();
                    noise = $urandom_range(1) ? ($urandom & 32'hFFFF_FC00) : 32'd0;
                    pick = $urandom_range(99);
                    program_knob(slt_pkg::REG_DEPTH, noise | (pick < 25 ? 32'd0 :
                                 pick < 50 ? 32'd1023 : 32'($urandom_range(1023))));
                    noise = $urandom_range(1) ? ($urandom & 32'hFFFF_FC00) : 32'd0;
                    pick = $urandom_range(99);
                    program_knob(slt_pkg::REG_RATE, noise | (pick < 50 ? 32'd1023 :
                                 pick < 65 ? 32'd0 : 32'($urandom_range(1023))));
                end
                // Pause the sender until the pipe is empty
                if (ph == 1 && n == 300) begin
                    drain_results();
                end
                // Hold off the receiver while beats keep coming
                if (ph == 2 && n == 60) begin
                    rx_hold_req <= ~rx_hold_req;
                end
                idle_sender();
                send_frame(pick_sample(), pick_sample(), 1'b0, 24'd0, 24'd0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && gained_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule
